### hw/rtl/emfp_pkg.sv
// Shared types and constants of the energy meter frame parser.
package emfp_pkg;

    localparam int FRAME_BYTES = 24;
    localparam int POS_W       = 5;
    // Bytes 2..22 are kept in a shift line so that the fields sit at fixed places.
    localparam int SHIFT_BYTES = 21;
    localparam int SHIFT_W     = SHIFT_BYTES * 8;

    localparam logic [POS_W-1:0] POS_START = 5'd0;
    localparam logic [POS_W-1:0] POS_SYNC  = 5'd1;
    localparam logic [POS_W-1:0] POS_LAST  = 5'(FRAME_BYTES - 1);

    localparam logic [7:0] SYNC_BYTE = 8'h5A;

    localparam int FLAG_OVF_BIT     = 7;
    localparam int FLAG_VOLTAGE_BIT = 6;
    localparam int FLAG_CURRENT_BIT = 5;
    localparam int FLAG_POWER_BIT   = 4;

    typedef struct packed {
        logic        status;
        logic [23:0] vpar;
        logic [23:0] vdat;
        logic [23:0] cpar;
        logic [23:0] cdat;
        logic [23:0] ppar;
        logic [23:0] pdat;
        logic [15:0] pulses;
        logic        upd_v;
        logic        upd_c;
        logic        upd_p;
        logic        upd_ovf;
    } frame_rec_t;

    typedef struct packed {
        logic full;
        logic valid;
    } q_stat_t;

endpackage

### hw/rtl/emfp_front.sv
// Front end: byte synchronisation, field capture and running checksum.
module emfp_front
    import emfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] rx_byte,
    input  logic       in_valid,
    output logic       in_ready,
    input  q_stat_t    q_stat,
    output logic       push,
    output frame_rec_t rec
);

    // Low bit of word24(k) in the shift line is (20 - k) * 8.
    localparam int VPAR_LSB  = (20 - 2) * 8;
    localparam int VDAT_LSB  = (20 - 5) * 8;
    localparam int CPAR_LSB  = (20 - 8) * 8;
    localparam int CDAT_LSB  = (20 - 11) * 8;
    localparam int PPAR_LSB  = (20 - 14) * 8;
    localparam int PDAT_LSB  = (20 - 17) * 8;
    localparam int FLAGS_LSB = (22 - 20) * 8;

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [7:0]         sum_reg, sum_next;
    logic [SHIFT_W-1:0] shift_reg, shift_next;
    logic               accept;
    logic               good;
    logic [7:0]         flags;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        shift_next = shift_reg;
        push       = 1'b0;
        if (accept)
        begin
            if (pos_reg == POS_START)
            begin
                pos_next = POS_SYNC;
            end
            else if (pos_reg == POS_SYNC)
            begin
                // A wrong sync byte becomes the first byte of the next candidate.
                pos_next = (rx_byte == SYNC_BYTE) ? POS_SYNC + 5'd1 : POS_SYNC;
                sum_next = 8'd0;
            end
            else if (pos_reg == POS_LAST)
            begin
                pos_next = POS_START;
                push     = 1'b1;
            end
            else
            begin
                pos_next   = pos_reg + 5'd1;
                sum_next   = sum_reg + rx_byte;
                shift_next = {shift_reg[SHIFT_W-9:0], rx_byte};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_START;
            sum_reg <= 8'd0;
        end
        else
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    assign good  = (sum_reg == rx_byte);
    assign flags = shift_reg[FLAGS_LSB +: 8];

    always_comb
    begin
        rec.status  = !good;
        rec.vpar    = good ? shift_reg[VPAR_LSB +: 24] : 24'd0;
        rec.cpar    = good ? shift_reg[CPAR_LSB +: 24] : 24'd0;
        rec.ppar    = good ? shift_reg[PPAR_LSB +: 24] : 24'd0;
        rec.pulses  = good ? shift_reg[15:0] : 16'd0;
        rec.vdat    = shift_reg[VDAT_LSB +: 24];
        rec.cdat    = shift_reg[CDAT_LSB +: 24];
        rec.pdat    = shift_reg[PDAT_LSB +: 24];
        rec.upd_v   = good && flags[FLAG_VOLTAGE_BIT];
        rec.upd_c   = good && flags[FLAG_CURRENT_BIT];
        rec.upd_p   = good && flags[FLAG_POWER_BIT];
        rec.upd_ovf = good && flags[FLAG_OVF_BIT];
    end

endmodule

### hw/rtl/emfp_queue.sv
// Two-entry queue of completed frame records between front and back end.
module emfp_queue
    import emfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  frame_rec_t push_rec,
    input  logic       pop,
    output frame_rec_t pop_rec,
    output q_stat_t    q_stat
);

    frame_rec_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign q_stat.full  = (count_reg == 2'd2);
    assign q_stat.valid = (count_reg != 2'd0);
    assign pop_rec      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

### hw/rtl/emfp_back.sv
// Back end: held data words, overflow counter and the result register.
module emfp_back
    import emfp_pkg::*;
#(
    parameter int OVERFLOW_COUNT_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_stat_t     q_stat,
    input  frame_rec_t  rec,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        status,
    output logic [23:0] voltage_param,
    output logic [23:0] voltage_reg,
    output logic [23:0] current_param,
    output logic [23:0] current_reg,
    output logic [23:0] power_param,
    output logic [23:0] power_reg,
    output logic [15:0] pulse_count,
    output logic [31:0] pulse_overflows
);

    localparam int CW = OVERFLOW_COUNT_WIDTH;

    logic [23:0]   held_v_reg, held_v_next;
    logic [23:0]   held_c_reg, held_c_next;
    logic [23:0]   held_p_reg, held_p_next;
    logic [CW-1:0] ovf_cnt_reg, ovf_cnt_next;
    logic          out_valid_reg, out_valid_next;

    logic          out_status_reg;
    logic [23:0]   out_vpar_reg, out_vdat_reg;
    logic [23:0]   out_cpar_reg, out_cdat_reg;
    logic [23:0]   out_ppar_reg, out_pdat_reg;
    logic [15:0]   out_pulses_reg;
    logic [CW-1:0] out_ovf_reg;

    // The result register frees up in the same cycle it is taken.
    assign pop = q_stat.valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        held_v_next    = (pop && rec.upd_v) ? rec.vdat : held_v_reg;
        held_c_next    = (pop && rec.upd_c) ? rec.cdat : held_c_reg;
        held_p_next    = (pop && rec.upd_p) ? rec.pdat : held_p_reg;
        ovf_cnt_next   = (pop && rec.upd_ovf) ? ovf_cnt_reg + CW'(1) : ovf_cnt_reg;
        out_valid_next = pop || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_v_reg    <= 24'd0;
            held_c_reg    <= 24'd0;
            held_p_reg    <= 24'd0;
            ovf_cnt_reg   <= {{(CW-1){1'b0}}, 1'b1};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            held_v_reg    <= held_v_next;
            held_c_reg    <= held_c_next;
            held_p_reg    <= held_p_next;
            ovf_cnt_reg   <= ovf_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_status_reg <= rec.status;
            out_vpar_reg   <= rec.vpar;
            out_cpar_reg   <= rec.cpar;
            out_ppar_reg   <= rec.ppar;
            out_pulses_reg <= rec.pulses;
            out_vdat_reg   <= held_v_next;
            out_cdat_reg   <= held_c_next;
            out_pdat_reg   <= held_p_next;
            out_ovf_reg    <= ovf_cnt_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign voltage_param = out_vpar_reg;
    assign voltage_reg   = out_vdat_reg;
    assign current_param = out_cpar_reg;
    assign current_reg   = out_cdat_reg;
    assign power_param   = out_ppar_reg;
    assign power_reg     = out_pdat_reg;
    assign pulse_count   = out_pulses_reg;

    generate
        if (CW >= 32)
        begin : g_ovf_trunc
            assign pulse_overflows = out_ovf_reg[31:0];
        end
        else
        begin : g_ovf_ext
            assign pulse_overflows = {{(32-CW){1'b0}}, out_ovf_reg};
        end
    endgenerate

endmodule

### hw/rtl/energy_meter_frame_parser.sv
// Energy meter frame parser: frames serial bytes into 24-byte packets and decodes them.
//
// Input channel: one received byte per transfer on rx_byte, handshaked by
// in_valid and in_ready, taken one per cycle unless the queue is full. The parser hunts
// for a packet whose second byte is 0x5A, sliding on by one byte otherwise.
// Output channel: one result per completed packet, handshaked by out_valid
// and out_ready. status is 0 when the checksum over bytes 2..22 matches
// byte 23; the parameter words and pulse count are then the packet's, and
// the held data words and overflow counter show their updated values. With
// a bad checksum status is 1, the parameter words and pulse count are zero
// and the held values are reported unchanged.
// Each packet's record is written into the queue and then moved into the result
// register, which raises out_valid; a stalled receiver can hold up that move.
// A two-entry queue of decoded packets sits between the byte front end and
// the result register, so a stalled receiver holds up the input only once
// two further packets have completed and are waiting.
// Reset: the held voltage, current and power words clear to zero, the
// overflow counter starts at one and the byte search starts afresh.
module energy_meter_frame_parser
    import emfp_pkg::*;
#(
    parameter int OVERFLOW_COUNT_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  rx_byte,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        status,
    output logic [23:0] voltage_param,
    output logic [23:0] voltage_reg,
    output logic [23:0] current_param,
    output logic [23:0] current_reg,
    output logic [23:0] power_param,
    output logic [23:0] power_reg,
    output logic [15:0] pulse_count,
    output logic [31:0] pulse_overflows
);

    q_stat_t    q_stat;
    logic       push;
    logic       pop;
    frame_rec_t push_rec;
    frame_rec_t pop_rec;

    emfp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_byte  (rx_byte),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .q_stat   (q_stat),
        .push     (push),
        .rec      (push_rec)
    );

    emfp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .q_stat   (q_stat)
    );

    emfp_back #(
        .OVERFLOW_COUNT_WIDTH (OVERFLOW_COUNT_WIDTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_stat          (q_stat),
        .rec             (pop_rec),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .voltage_param   (voltage_param),
        .voltage_reg     (voltage_reg),
        .current_param   (current_param),
        .current_reg     (current_reg),
        .power_param     (power_param),
        .power_reg       (power_reg),
        .pulse_count     (pulse_count),
        .pulse_overflows (pulse_overflows)
    );

    // A packet record is only produced by a byte transfer.
    a_push_on_transfer : assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (in_valid && in_ready))
        else $error("packet record pushed without a byte transfer");

    // The queue is never written while full.
    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("packet queue overflow");

    // A rejected packet reports zero parameter words and pulse count.
    a_bad_zeroed : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (voltage_param == 24'd0 && current_param == 24'd0
                                   && power_param == 24'd0 && pulse_count == 16'd0))
        else $error("bad packet result carries nonzero fields");

endmodule
